/* sv/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared constants, opcodes and controller/datapath interface types for the
// huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // default sizing
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  // field widths
  localparam int OP_W       = 2;
  localparam int SYM_W      = 8;
  localparam int LEN_W      = 6;
  localparam int CODE_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int PAD_W      = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic tbl_wr;      // write table entry from input fields
    logic tbl_rd;      // read table entry for input symbol
    logic load_work;   // move read entry into code and length registers
    logic pack_step;   // merge one chunk of code bits into the byte
    logic flush_emit;  // emit partial byte and clear it
  } hcbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sym_ok;          // symbol below table depth
    logic rem_zero;        // no code bits left
    logic step_full;       // this step completes a byte
    logic rem_after_zero;  // this step uses up the code
    logic out_free;        // output register can take a result
  } hcbp_sts_t;

endpackage

/* sv/hcbp_ctrl.sv */
// ----------------------------------------------------------------------------
// hcbp_ctrl
// sequencer: accepts items, walks an encode through lookup and packing steps,
// holds a byte-completing step or a flush while the output register is occupied
// ----------------------------------------------------------------------------
module hcbp_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic [hcbp_pkg::OP_W-1:0]         in_opcode,
  output logic                              in_tready,
  input  hcbp_pkg::hcbp_sts_t               sts,
  output hcbp_pkg::hcbp_cmd_t               cmd
);
  import hcbp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_PACK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_opcode)
            OP_LOAD: begin
              cmd.tbl_wr = sts.sym_ok;
            end
            OP_ENCODE: begin
              if (sts.sym_ok) begin
                cmd.tbl_rd = 1'b1;
                state_nxt  = ST_READ;
              end
            end
            OP_FLUSH: begin
              state_nxt = ST_FLUSH;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.load_work = 1'b1;
        state_nxt     = ST_PACK;
      end
      ST_PACK: begin
        if (sts.rem_zero) begin
          state_nxt = ST_IDLE;
        end else if (!sts.step_full || sts.out_free) begin
          cmd.pack_step = 1'b1;
          if (sts.rem_after_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/hcbp_dp.sv */
// ----------------------------------------------------------------------------
// hcbp_dp
// code table memory, code shifter, byte accumulator and output register
// ----------------------------------------------------------------------------
module hcbp_dp #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hcbp_pkg::hcbp_cmd_t               cmd,
  output hcbp_pkg::hcbp_sts_t               sts,
  input  logic [hcbp_pkg::SYM_W-1:0]        in_symbol,
  input  logic [hcbp_pkg::LEN_W-1:0]        in_code_length,
  input  logic [hcbp_pkg::CODE_W-1:0]       in_code_bits,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [hcbp_pkg::BYTE_W-1:0]       out_packed_byte,
  output logic                              out_byte_valid,
  output logic [hcbp_pkg::PAD_W-1:0]        out_pad_count,
  output logic                              out_last_of_run
);
  import hcbp_pkg::*;

  localparam int IW = $clog2(SYMBOL_COUNT);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int EW = LW + MAX_CODE_LEN;

  // code table
  logic [EW-1:0] mem [SYMBOL_COUNT];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] tbl_idx;
  logic [LW-1:0] len_sat;

  assign tbl_idx = in_symbol[IW-1:0];
  assign len_sat = (in_code_length > LEN_W'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                           : in_code_length[LW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      mem[tbl_idx] <= {len_sat, in_code_bits[MAX_CODE_LEN-1:0]};
    end
    if (cmd.tbl_rd) begin
      rd_data_r <= mem[tbl_idx];
    end
  end

  // working registers
  logic [MAX_CODE_LEN-1:0] code_r;
  logic [LW-1:0]           rem_r;
  logic [BYTE_W-1:0]       acc_r;
  logic [2:0]              fill_r;
  logic [BYTE_W-1:0]       acc_nxt;
  logic [2:0]              fill_nxt;

  logic [3:0]        avail;
  logic [LW-1:0]     take;
  logic [3:0]        take4;
  logic [3:0]        fill_sum;
  logic [LW-1:0]     rem_after;
  logic [BYTE_W-1:0] rev;
  logic [BYTE_W-1:0] shifted;
  logic [BYTE_W-1:0] new_bits;
  logic [BYTE_W-1:0] acc_merge;
  logic              step_full;
  logic              out_valid_r;

  assign avail     = 4'd8 - {1'b0, fill_r};
  assign take      = (rem_r < LW'(avail)) ? rem_r : LW'(avail);
  assign take4     = take[3:0];
  assign fill_sum  = {1'b0, fill_r} + take4;
  assign step_full = (fill_sum == 4'd8);
  assign rem_after = rem_r - take;

  // first code bit lands at the highest free byte position
  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      rev[BYTE_W-1-i] = code_r[i];
    end
    shifted = rev >> fill_r;
    for (int j = 0; j < BYTE_W; j++) begin
      new_bits[BYTE_W-1-j] = shifted[BYTE_W-1-j] & (4'(j) >= {1'b0, fill_r})
                             & (4'(j) < fill_sum);
    end
  end

  assign acc_merge = acc_r | new_bits;

  always_comb begin
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    if (cmd.pack_step) begin
      acc_nxt  = step_full ? '0 : acc_merge;
      fill_nxt = step_full ? 3'd0 : fill_sum[2:0];
    end else if (cmd.flush_emit) begin
      acc_nxt  = '0;
      fill_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fill_r <= 3'd0;
      rem_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
      if (cmd.load_work) begin
        rem_r <= rd_data_r[EW-1:MAX_CODE_LEN];
      end else if (cmd.pack_step) begin
        rem_r <= rem_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      code_r <= rd_data_r[MAX_CODE_LEN-1:0];
    end else if (cmd.pack_step) begin
      code_r <= code_r >> take4;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.pack_step && step_full) || cmd.flush_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack_step && step_full) begin
      out_packed_byte <= acc_merge;
      out_byte_valid  <= 1'b1;
      out_pad_count   <= '0;
      out_last_of_run <= (rem_after < LW'(8));
    end else if (cmd.flush_emit) begin
      out_packed_byte <= acc_r;
      out_byte_valid  <= (fill_r != 3'd0);
      out_pad_count   <= PAD_W'(4'd8 - {1'b0, fill_r});
      out_last_of_run <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

  assign sts.sym_ok         = ({1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign sts.rem_zero       = (rem_r == '0);
  assign sts.step_full      = step_full;
  assign sts.rem_after_zero = (rem_after == '0);
  assign sts.out_free       = !out_valid_r || out_tready;

endmodule

/* sv/huffman_code_bit_packer_top.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// variable-length code packer: table of codes per byte symbol, bit packing
// msb first into bytes, flush of the partial byte with padding count
// ----------------------------------------------------------------------------
//
//  channel | direction | transaction carries
//  --------+-----------+-----------------------------------------------------
//  in_*    | slave     | opcode in tuser; symbol, code_length, code_bits in tdata
//  out_*   | master    | byte_valid in tuser; packed_byte, pad_count in tdata;
//          |           | last_of_run in tlast
//
//  load: in_tready returns the cycle after acceptance
//  encode: table memory read port, then a registered read into the working registers,
//    then one packing step per output byte touched, at most 5 for a 32-bit code; a zero-length
//    code takes no packing step
//  flush: emitted from ST_FLUSH; a step that fills a byte or a flush waits while the output
//    register holds an untaken result
//  a new item is accepted while the last result of the previous one is waiting
//  reset: rst_n synchronous active low, clears accumulator and control; the
//    code table is not cleared and must be loaded before use
//
module huffman_code_bit_packer_top #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hcbp_pkg::IN_DATA_W-1:0]      in_tdata,   // symbol[7:0], code_length[13:8],
                                                          // code_bits[45:14], zero[47:46]
  input  logic [hcbp_pkg::OP_W-1:0]           in_tuser,   // opcode[1:0]
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hcbp_pkg::OUT_DATA_W-1:0]     out_tdata,  // packed_byte[7:0], pad_count[10:8],
                                                          // zero[15:11]
  output logic                                out_tuser,  // byte_valid
  output logic                                out_tlast   // last_of_run
);
  import hcbp_pkg::*;

  hcbp_cmd_t cmd;
  hcbp_sts_t sts;

  // input field unpacking
  logic [SYM_W-1:0]  in_symbol;
  logic [LEN_W-1:0]  in_code_length;
  logic [CODE_W-1:0] in_code_bits;

  assign in_symbol      = in_tdata[SYM_W-1:0];
  assign in_code_length = in_tdata[SYM_W+LEN_W-1:SYM_W];
  assign in_code_bits   = in_tdata[SYM_W+LEN_W+CODE_W-1:SYM_W+LEN_W];

  // result fields
  logic [BYTE_W-1:0] out_packed_byte;
  logic [PAD_W-1:0]  out_pad_count;

  assign out_tdata = {(OUT_DATA_W - PAD_W - BYTE_W)'(0), out_pad_count, out_packed_byte};

  // sequencer
  hcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, packing datapath and output register
  hcbp_dp #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_symbol       (in_symbol),
    .in_code_length  (in_code_length),
    .in_code_bits    (in_code_bits),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_packed_byte (out_packed_byte),
    .out_byte_valid  (out_tuser),
    .out_pad_count   (out_pad_count),
    .out_last_of_run (out_tlast)
  );

  // a load never keeps the block busy
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_LOAD) |=> in_tready)
    else $error("load transaction left the block busy");

  // an empty flush result carries a zero byte and zero padding
  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == '0) && out_tlast)
    else $error("empty flush result with data or padding");

  // padding only appears on a final flush result that carries data
  a_pad_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10:8] != 3'd0) |-> out_tlast && out_tuser)
    else $error("padding count on a non-final result");

  // the block is busy in the cycle after a flush is taken
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_FLUSH) |=> !in_tready)
    else $error("flush transaction did not occupy the sequencer");

endmodule
